/* rtl/rcv_pkg.sv */
// Shared types, constants and mode decoding for the radix converter.
package rcv_pkg;

  localparam int MODE_W          = 4;
  localparam int VAL_W           = 63;
  localparam int OPERAND_DIGITS  = 19;
  localparam int BCD_DIGITS      = OPERAND_DIGITS + 1;
  localparam int BCD_W           = 4 * BCD_DIGITS;
  localparam int DABBLE_BITS     = 3;
  localparam int DABBLE_STEPS    = (VAL_W + DABBLE_BITS - 1) / DABBLE_BITS;
  localparam int WEIGHT_STEPS    = BCD_DIGITS / 2;
  localparam int CNT_W           = $clog2(DABBLE_STEPS);
  localparam int IDX_W           = $clog2(OPERAND_DIGITS);
  localparam int VPOS_W          = $clog2(VAL_W);
  localparam int NUM_MODES       = 12;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_BIN_OCT = 4'd0;
  localparam mode_t MODE_BIN_DEC = 4'd1;
  localparam mode_t MODE_BIN_HEX = 4'd2;
  localparam mode_t MODE_OCT_BIN = 4'd3;
  localparam mode_t MODE_OCT_DEC = 4'd4;
  localparam mode_t MODE_OCT_HEX = 4'd5;
  localparam mode_t MODE_DEC_BIN = 4'd6;
  localparam mode_t MODE_DEC_OCT = 4'd7;
  localparam mode_t MODE_DEC_HEX = 4'd8;
  localparam mode_t MODE_HEX_BIN = 4'd9;
  localparam mode_t MODE_HEX_OCT = 4'd10;
  localparam mode_t MODE_HEX_DEC = 4'd11;

  // Number form: plain value, or digit-packed base 2 / base 8.
  typedef logic [1:0] form_t;
  localparam form_t FORM_PLAIN = 2'd0;
  localparam form_t FORM_BIN   = 2'd1;
  localparam form_t FORM_OCT   = 2'd2;

  typedef logic [1:0] alu_op_t;
  localparam alu_op_t OP_DABBLE = 2'd0;
  localparam alu_op_t OP_WEIGHT = 2'd1;
  localparam alu_op_t OP_PACK   = 2'd2;

  typedef struct packed {
    alu_op_t          op;
    logic             oct;
    logic             sat;
    logic [IDX_W-1:0] digit_idx;
  } alu_ctrl_t;

  function automatic logic mode_known(input mode_t m);
    return m < MODE_W'(NUM_MODES);
  endfunction

  function automatic form_t src_form(input mode_t m);
    form_t f;
    case (m) inside
      MODE_BIN_OCT, MODE_BIN_DEC, MODE_BIN_HEX: f = FORM_BIN;
      MODE_OCT_BIN, MODE_OCT_DEC, MODE_OCT_HEX: f = FORM_OCT;
      default:                                  f = FORM_PLAIN;
    endcase
    return f;
  endfunction

  function automatic form_t dst_form(input mode_t m);
    form_t f;
    case (m) inside
      MODE_OCT_BIN, MODE_DEC_BIN, MODE_HEX_BIN: f = FORM_BIN;
      MODE_BIN_OCT, MODE_DEC_OCT, MODE_HEX_OCT: f = FORM_OCT;
      default:                                  f = FORM_PLAIN;
    endcase
    return f;
  endfunction

endpackage

/* rtl/rcv_if.sv */
// Request and result channel interfaces of the radix converter.
interface rcv_req_if import rcv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [VAL_W-1:0]  operand;

  modport source(output valid, mode, operand, input ready);
  modport sink(input valid, mode, operand, output ready);
endinterface

interface rcv_rsp_if import rcv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] converted;
  logic             overflow;

  modport source(output valid, converted, overflow, input ready);
  modport sink(input valid, converted, overflow, output ready);
endinterface

/* rtl/rcv_alu.sv */
// Shared datapath unit: BCD shift-and-adjust, radix weighting and decimal packing.
module rcv_alu import rcv_pkg::*; (
  input  alu_ctrl_t        ctrl,
  input  logic [BCD_W-1:0] bcd,
  input  logic [VAL_W-1:0] num,
  input  logic [VAL_W-1:0] acc,
  output logic [BCD_W-1:0] bcd_out,
  output logic [VAL_W-1:0] num_out,
  output logic [VAL_W-1:0] acc_out
);

  // Adjust every BCD digit that is five or more, then shift in one bit.
  function automatic logic [BCD_W-1:0] dabble_shift(input logic [BCD_W-1:0] b,
                                                    input logic bit_in);
    logic [BCD_W-1:0] adj;
    adj = b;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

  logic [BCD_W-1:0]  dabbled;
  logic [3:0]        d_hi;
  logic [3:0]        d_lo;
  logic [3:0]        pack_digit;
  logic [VPOS_W-1:0] bin_pos;
  logic [VPOS_W-1:0] oct_pos;

  always_comb begin
    dabbled = bcd;
    for (int j = 0; j < DABBLE_BITS; j++) begin
      dabbled = dabble_shift(dabbled, num[VAL_W-1-j]);
    end
  end

  assign d_hi    = bcd[BCD_W-1 -: 4];
  assign d_lo    = bcd[BCD_W-5 -: 4];
  assign bin_pos = VPOS_W'(ctrl.digit_idx);
  assign oct_pos = VPOS_W'(ctrl.digit_idx) * VPOS_W'(3);

  always_comb begin
    if (ctrl.sat) begin
      pack_digit = ctrl.oct ? 4'd7 : 4'd1;
    end else if (ctrl.oct) begin
      pack_digit = {1'b0, num[oct_pos +: 3]};
    end else begin
      pack_digit = {3'b000, num[bin_pos]};
    end
  end

  always_comb begin
    bcd_out = bcd;
    num_out = num;
    acc_out = acc;
    unique case (ctrl.op)
      OP_DABBLE: begin
        bcd_out = dabbled;
        num_out = num << DABBLE_BITS;
      end
      OP_WEIGHT: begin
        bcd_out = bcd << 8;
        if (ctrl.oct) begin
          acc_out = (acc << 6) + VAL_W'({d_hi, 3'b000}) + VAL_W'(d_lo);
        end else begin
          acc_out = (acc << 2) + VAL_W'({d_hi, 1'b0}) + VAL_W'(d_lo);
        end
      end
      OP_PACK: begin
        acc_out = (acc << 3) + (acc << 1) + VAL_W'(pack_digit);
      end
      default: begin
        acc_out = acc;
      end
    endcase
  end

endmodule

/* rtl/radix_converter_core.sv */
// Top level of the radix converter: sequencer, working registers and result register.
//
//   channel   | side   | payload                      | item
//   ----------+--------+------------------------------+-----------------------------
//   request   | sink   | mode[3:0], operand[62:0]     | one conversion to run
//   result    | source | converted[62:0], overflow    | one converted number
//
// Sequencing: an item runs alone through one shared unit. A packed source is decoded
// by double-dabble steps (3 operand bits each), then weighting steps (2 digits each);
// a packed target is built by packing steps (one digit each). The accept and finish
// states frame these passes; a new item is taken only once the last has finished.
// Reset (rst, synchronous) returns the sequencer to idle and drops any held result.
// A stalled result holds in the output register; the next item is taken meanwhile.
module radix_converter_core import rcv_pkg::*; #(
  parameter int MAX_DIGITS = 19
) (
  input  logic      clk,
  input  logic      rst,
  rcv_req_if.sink   request,
  rcv_rsp_if.source result
);

  localparam int BIN_LIMIT = MAX_DIGITS;
  localparam int OCT_LIMIT = 3 * MAX_DIGITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DABBLE = 3'd1;
  localparam logic [2:0] ST_WEIGHT = 3'd2;
  localparam logic [2:0] ST_PACK   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]       state;
  logic [CNT_W-1:0] cnt;
  form_t            srcf;
  form_t            dstf;
  logic             sat;
  logic [VAL_W-1:0] num;
  logic [VAL_W-1:0] acc;
  logic [BCD_W-1:0] bcd;
  logic             out_valid;
  logic [VAL_W-1:0] out_conv;
  logic             out_ovf;

  alu_ctrl_t        ctrl;
  logic [BCD_W-1:0] alu_bcd;
  logic [VAL_W-1:0] alu_num;
  logic [VAL_W-1:0] alu_acc;

  logic             req_take;
  form_t            req_src;
  form_t            req_dst;
  logic [VAL_W-1:0] req_val;
  form_t            enter_dst;
  logic [VAL_W-1:0] enter_val;
  logic             enter_sat;
  logic             finish_load;

  assign request.ready    = (state == ST_IDLE);
  assign req_take         = request.valid && request.ready;
  assign req_src          = src_form(request.mode);
  assign req_dst          = dst_form(request.mode);
  // Unknown modes convert a zero plain value.
  assign req_val          = mode_known(request.mode) ? request.operand : '0;

  assign result.valid     = out_valid;
  assign result.converted = out_conv;
  assign result.overflow  = out_ovf;

  // A finishing item moves into the output register once it is free or being taken.
  assign finish_load      = (state == ST_FINISH) && (!out_valid || result.ready);

  // Value and target form at the point the packing pass starts.
  always_comb begin
    enter_dst = (state == ST_IDLE) ? req_dst : dstf;
    enter_val = (state == ST_IDLE) ? req_val : alu_acc;
    if (enter_dst == FORM_OCT) begin
      enter_sat = (enter_val >> OCT_LIMIT) != '0;
    end else begin
      enter_sat = (enter_val >> BIN_LIMIT) != '0;
    end
  end

  // Drive the shared unit from the sequencer state.
  always_comb begin
    ctrl.sat       = sat;
    ctrl.digit_idx = IDX_W'(MAX_DIGITS - 1) - cnt[IDX_W-1:0];
    unique case (state)
      ST_DABBLE: begin
        ctrl.op  = OP_DABBLE;
        ctrl.oct = 1'b0;
      end
      ST_WEIGHT: begin
        ctrl.op  = OP_WEIGHT;
        ctrl.oct = (srcf == FORM_OCT);
      end
      default: begin
        ctrl.op  = OP_PACK;
        ctrl.oct = (dstf == FORM_OCT);
      end
    endcase
  end

  rcv_alu u_alu (
    .ctrl    (ctrl),
    .bcd     (bcd),
    .num     (num),
    .acc     (acc),
    .bcd_out (alu_bcd),
    .num_out (alu_num),
    .acc_out (alu_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      // Refill with a finishing item, else drop the held result once taken.
      if (finish_load) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take) begin
            srcf <= req_src;
            dstf <= req_dst;
            num  <= req_val;
            bcd  <= '0;
            acc  <= '0;
            cnt  <= '0;
            sat  <= enter_sat;
            if (req_src != FORM_PLAIN) begin
              state <= ST_DABBLE;
            end else if (req_dst != FORM_PLAIN) begin
              state <= ST_PACK;
            end else begin
              state <= ST_FINISH;
            end
          end
        end
        ST_DABBLE: begin
          bcd <= alu_bcd;
          num <= alu_num;
          if (cnt == CNT_W'(DABBLE_STEPS - 1)) begin
            cnt   <= '0;
            state <= ST_WEIGHT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WEIGHT: begin
          bcd <= alu_bcd;
          if (cnt == CNT_W'(WEIGHT_STEPS - 1)) begin
            // Hand the decoded value over and clear the accumulator for packing.
            num <= alu_acc;
            acc <= '0;
            cnt <= '0;
            sat <= enter_sat;
            state <= (dstf != FORM_PLAIN) ? ST_PACK : ST_FINISH;
          end else begin
            acc <= alu_acc;
            cnt <= cnt + 1'b1;
          end
        end
        ST_PACK: begin
          acc <= alu_acc;
          if (cnt == CNT_W'(MAX_DIGITS - 1)) begin
            cnt   <= '0;
            state <= ST_FINISH;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free.
          if (finish_load) begin
            out_conv  <= (dstf == FORM_PLAIN) ? num : acc;
            out_ovf   <= (dstf != FORM_PLAIN) && sat;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/rcv_checker.sv */
// Port-level checks for the radix converter and their binding to the top level.
module rcv_checker import rcv_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic [VAL_W-1:0] rsp_converted,
  input logic             rsp_overflow
);

  // One item at a time: no new item right after one is taken.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request ready the cycle after an item was taken");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_converted) && $stable(rsp_overflow))
    else $error("stalled result changed");

  // A saturated result is never zero.
  a_ovf_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_overflow |-> rsp_converted != '0)
    else $error("overflow with zero result");

  // Reset drops any held result.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind radix_converter_core rcv_checker u_rcv_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (request.valid),
  .req_ready     (request.ready),
  .rsp_valid     (result.valid),
  .rsp_ready     (result.ready),
  .rsp_converted (result.converted),
  .rsp_overflow  (result.overflow)
);
